[rtl/core/tmp_pkg.sv]
// ----------------------------------------------------------------------------
// tmp_pkg
// Shared types, constants and saturation helpers for the trapezoidal motion
// profiler and its shared multiply/divide unit.
// ----------------------------------------------------------------------------
package tmp_pkg;

    localparam int POS_W     = 48;
    localparam int SPD_W     = 32;
    localparam int SLICE_W   = 24;
    localparam int OPA_W     = 63;
    localparam int OPB_W     = 49;
    localparam int ACC_W     = 96;
    localparam int MUL_STEPS = 32;
    localparam int DIV_STEPS = 63;
    localparam int CNT_W     = 6;

    localparam logic [POS_W-1:0]   POS_MAX     = 48'h7FFF_FFFF_FFFF;
    localparam logic [POS_W-1:0]   POS_MIN     = 48'h8000_0000_0000;
    localparam logic [SPD_W-1:0]   SPD_MAX     = 32'h7FFF_FFFF;
    localparam logic [SPD_W-1:0]   SPD_MIN     = 32'h8000_0000;
    localparam logic [OPA_W-1:0]   DV_BIG      = 63'h4000_0000_0000_0000;
    localparam logic [SLICE_W-1:0] SLICE_RESET = 24'd167772;

    localparam logic [1:0] MODE_POSITION = 2'd0;
    localparam logic [1:0] MODE_HOLD     = 2'd1;
    localparam logic [1:0] MODE_TRAP     = 2'd2;
    localparam logic [1:0] MODE_OFF      = 2'd3;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_CMD  = 1'b1;

    localparam logic CFG_SLICE = 1'b0;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ACC_GO,
        ST_ACC_WAIT,
        ST_SQ_GO,
        ST_SQ_WAIT,
        ST_BRK_GO,
        ST_BRK_WAIT,
        ST_STEPM_GO,
        ST_STEPM_WAIT,
        ST_PLAN,
        ST_QDIV_GO,
        ST_QDIV_WAIT,
        ST_QMUL_GO,
        ST_QMUL_WAIT,
        ST_DV,
        ST_STEP_GO,
        ST_STEP_WAIT,
        ST_UPD,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        UOP_MUL,
        UOP_MULSL,
        UOP_DIV
    } uop_t;

    typedef struct packed {
        logic start;
        uop_t op;
    } unit_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W+1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > $signed({2'b00, POS_MAX})) begin
            r = POS_MAX;
        end else if (v < $signed({2'b11, POS_MIN})) begin
            r = POS_MIN;
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [SPD_W-1:0] sat_spd(input logic signed [SPD_W+3:0] v);
        logic signed [SPD_W-1:0] r;
        if (v > $signed({4'h0, SPD_MAX})) begin
            r = SPD_MAX;
        end else if (v < $signed({4'hF, SPD_MIN})) begin
            r = SPD_MIN;
        end else begin
            r = v[SPD_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/core/tmp_muldiv.sv]
// ----------------------------------------------------------------------------
// tmp_muldiv
// Shared bit-serial unit: shift-add multiply (full or scaled by 2^-24) and
// restoring divide.
// ----------------------------------------------------------------------------
module tmp_muldiv
    import tmp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  unit_ctrl_t       ctrl,
    input  logic [OPA_W-1:0] op_a,
    input  logic [OPB_W-1:0] op_b,
    output unit_stat_t       stat,
    output logic [OPA_W-1:0] result
);

    logic             busy_reg;
    logic             done_reg;
    uop_t             op_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [OPA_W-1:0] a_reg;
    logic [OPB_W-1:0] d_reg;
    logic [OPB_W-1:0] rem_reg;

    logic [64:0]      mul_sum;
    logic [ACC_W-1:0] mul_next;
    logic [OPB_W:0]   trial;
    logic [OPB_W:0]   trial_sub;
    logic             fits;
    logic [ACC_W-1:0] div_next;
    logic [OPB_W-1:0] rem_next;

    always_comb begin
        mul_sum   = {1'b0, acc_reg[95:32]} + {2'b00, a_reg};
        mul_next  = acc_reg[0] ? {mul_sum, acc_reg[31:1]} : {1'b0, acc_reg[95:1]};
        trial     = {rem_reg, acc_reg[62]};
        fits      = (trial >= {1'b0, d_reg});
        trial_sub = trial - {1'b0, d_reg};
        rem_next  = fits ? trial_sub[OPB_W-1:0] : trial[OPB_W-1:0];
        div_next  = {acc_reg[95:63], acc_reg[61:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= (ctrl.op == UOP_DIV) ? CNT_W'(DIV_STEPS - 1)
                                                 : CNT_W'(MUL_STEPS - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            op_reg  <= ctrl.op;
            a_reg   <= op_a;
            d_reg   <= op_b;
            rem_reg <= '0;
            acc_reg <= (ctrl.op == UOP_DIV) ? {33'b0, op_a} : {64'b0, op_b[31:0]};
        end else if (busy_reg) begin
            if (op_reg == UOP_DIV) begin
                acc_reg <= div_next;
                rem_reg <= rem_next;
            end else begin
                acc_reg <= mul_next;
            end
        end
    end

    always_comb begin
        case (op_reg)
            UOP_MULSL: result = acc_reg[86:24];
            UOP_MUL:   result = acc_reg[62:0];
            UOP_DIV:   result = acc_reg[62:0];
            default:   result = acc_reg[62:0];
        endcase
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

[rtl/core/trapezoid_motion_profiler.sv]
// sequence: command word or idle tick goes from accept straight to the result; busy tick
// runs multiplies (position/hold modes) or multiplies and divides (trapezoid/off) on the
// shared bit-serial unit
// throughput: one word at a time, next word taken in idle after the result is registered
// reset: synchronous active low, clears position, speed, command and busy
// ----------------------------------------------------------------------------
// trapezoid_motion_profiler
// Simulated motor profile generator with trapezoidal ramps in fixed point,
// sequenced over one shared multiply/divide unit.
// ----------------------------------------------------------------------------
module trapezoid_motion_profiler
    import tmp_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_kind,
    input  logic [1:0]              s_ctrl_mode,
    input  logic                    s_absolute_target,
    input  logic signed [POS_W-1:0] s_target_position,
    input  logic signed [SPD_W-1:0] s_cruise_speed,
    input  logic [30:0]             s_max_accel,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [POS_W-1:0] m_position,
    output logic signed [SPD_W-1:0] m_speed,
    output logic                    m_busy_res,
    output logic                    m_finished,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic                    cfg_index,
    input  logic [SLICE_W-1:0]      cfg_data
);

    state_t state_reg, state_next;

    logic signed [POS_W-1:0] pos_reg;
    logic signed [SPD_W-1:0] speed_reg;
    logic [1:0]              mode_reg;
    logic                    abs_reg;
    logic signed [POS_W-1:0] goal_reg;
    logic signed [SPD_W-1:0] cruise_reg;
    logic [30:0]             accel_reg;
    logic                    busy_reg;
    logic [SLICE_W-1:0]      slice_reg;
    logic                    fin_reg;

    logic                    m_valid_reg;
    logic signed [POS_W-1:0] m_position_reg;
    logic signed [SPD_W-1:0] m_speed_reg;
    logic                    m_busy_reg;
    logic                    m_fin_reg;

    logic [30:0]             accsl_reg;
    logic [OPA_W-1:0]        sq_reg;
    logic [POS_W-1:0]        brk_reg;
    logic [31:0]             stepm_reg;
    logic [POS_W-1:0]        absd_reg;
    logic signed [SPD_W-1:0] tgt_reg;
    logic [OPA_W-1:0]        dvmax_reg;
    logic signed [33:0]      sdv_reg;
    logic signed [34:0]      st_reg;

    unit_ctrl_t       unit_ctrl;
    unit_stat_t       unit_st;
    logic [OPA_W-1:0] unit_a;
    logic [OPB_W-1:0] unit_b;
    logic [OPA_W-1:0] unit_res;

    logic [OPB_W-1:0]        slice_b;
    logic [31:0]             s_abs_w;
    logic signed [32:0]      diff_w;
    logic [32:0]             dv_raw;
    logic [32:0]             dv_cap;
    logic                    diff_pos;
    logic signed [33:0]      sdv_w;
    logic signed [34:0]      s_w;
    logic [34:0]             s_mag_w;
    logic [34:0]             st_res;
    logic signed [34:0]      st_w;
    logic signed [POS_W+1:0] gp_dif;
    logic signed [POS_W-1:0] delta_w;
    logic [POS_W-1:0]        absd_w;
    logic [SPD_W-1:0]        cruise_neg;
    logic [30:0]             cm_w;
    logic signed [SPD_W-1:0] tgt_base;
    logic signed [POS_W+1:0] margin_w;
    logic signed [POS_W+1:0] stepm_x;
    logic signed [POS_W+1:0] stepm2_x;
    logic signed [SPD_W-1:0] plan_tgt;
    logic                    plan_arrive;
    logic signed [POS_W+1:0] snap_sum;
    logic signed [POS_W+1:0] pos_sum;
    logic signed [SPD_W+3:0] spd_sum;
    logic signed [POS_W+1:0] goal_dif;
    logic signed [SPD_W-1:0] spd_new;
    logic                    brake_mode;
    logic                    out_free;

    tmp_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (unit_ctrl),
        .op_a    (unit_a),
        .op_b    (unit_b),
        .stat    (unit_st),
        .result  (unit_res)
    );

    // datapath helpers
    always_comb begin
        slice_b    = {25'b0, slice_reg};
        brake_mode = (mode_reg == MODE_POSITION) || (mode_reg == MODE_HOLD);
        out_free   = !m_valid_reg || m_ready;

        s_abs_w  = speed_reg[31] ? (~speed_reg + 32'd1) : speed_reg;

        diff_w   = {speed_reg[31], speed_reg} - {tgt_reg[31], tgt_reg};
        dv_raw   = diff_w[32] ? (~diff_w + 33'd1) : diff_w;
        dv_cap   = ({30'b0, dv_raw} > dvmax_reg) ? dvmax_reg[32:0] : dv_raw;
        diff_pos = !diff_w[32] && (diff_w != '0);
        sdv_w    = diff_pos ? (~{1'b0, dv_cap} + 34'd1) : {1'b0, dv_cap};

        s_w      = {{2{speed_reg[31]}}, speed_reg, 1'b0} + {sdv_reg[33], sdv_reg};
        s_mag_w  = s_w[34] ? (~s_w + 35'd1) : s_w;
        st_res   = {1'b0, unit_res[34:1]};
        st_w     = s_w[34] ? (~st_res + 35'd1) : st_res;

        gp_dif   = {{2{goal_reg[47]}}, goal_reg} - {{2{pos_reg[47]}}, pos_reg};
        delta_w  = abs_reg ? sat_pos(gp_dif) : goal_reg;
        absd_w   = delta_w[47] ? (~delta_w + 48'd1) : delta_w;

        cruise_neg = ~cruise_reg + 32'd1;
        if (cruise_reg == SPD_MIN) begin
            cm_w = SPD_MAX[30:0];
        end else begin
            cm_w = cruise_reg[31] ? cruise_neg[30:0] : cruise_reg[30:0];
        end
        tgt_base = delta_w[47] ? (~{1'b0, cm_w} + 32'd1) : {1'b0, cm_w};

        margin_w = {2'b00, absd_w} - {2'b00, brk_reg};
        stepm_x  = {18'b0, stepm_reg};
        stepm2_x = {17'b0, stepm_reg, 1'b0};
        if (margin_w < stepm_x) begin
            plan_tgt = '0;
        end else if (margin_w <= stepm2_x) begin
            plan_tgt = speed_reg;
        end else begin
            plan_tgt = tgt_base;
        end
        plan_arrive = (absd_w <= {16'b0, stepm_reg}) && ({1'b0, s_abs_w} <= {2'b0, accsl_reg});

        snap_sum = {{2{pos_reg[47]}}, pos_reg} + {{2{delta_w[47]}}, delta_w};
        pos_sum  = {{2{pos_reg[47]}}, pos_reg} + {{15{st_reg[34]}}, st_reg};
        goal_dif = {{2{goal_reg[47]}}, goal_reg} - {{15{st_reg[34]}}, st_reg};
        spd_sum  = {{4{speed_reg[31]}}, speed_reg} + {{2{sdv_reg[33]}}, sdv_reg};
        spd_new  = sat_spd(spd_sum);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_kind == KIND_CMD || !busy_reg) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_ACC_GO;
                    end
                end
            end
            ST_ACC_GO:   state_next = ST_ACC_WAIT;
            ST_ACC_WAIT: begin
                if (unit_st.done) begin
                    state_next = brake_mode ? ST_DV : ST_SQ_GO;
                end
            end
            ST_SQ_GO:    state_next = ST_SQ_WAIT;
            ST_SQ_WAIT: begin
                if (unit_st.done) begin
                    state_next = (accel_reg == '0) ? ST_STEPM_GO : ST_BRK_GO;
                end
            end
            ST_BRK_GO:   state_next = ST_BRK_WAIT;
            ST_BRK_WAIT: begin
                if (unit_st.done) begin
                    state_next = ST_STEPM_GO;
                end
            end
            ST_STEPM_GO: state_next = ST_STEPM_WAIT;
            ST_STEPM_WAIT: begin
                if (unit_st.done) begin
                    state_next = ST_PLAN;
                end
            end
            ST_PLAN: begin
                if (plan_arrive) begin
                    state_next = ST_OUT;
                end else if (plan_tgt == '0 && absd_w != '0) begin
                    state_next = ST_QDIV_GO;
                end else begin
                    state_next = ST_DV;
                end
            end
            ST_QDIV_GO:  state_next = ST_QDIV_WAIT;
            ST_QDIV_WAIT: begin
                if (unit_st.done) begin
                    state_next = ST_QMUL_GO;
                end
            end
            ST_QMUL_GO:  state_next = ST_QMUL_WAIT;
            ST_QMUL_WAIT: begin
                if (unit_st.done) begin
                    state_next = ST_DV;
                end
            end
            ST_DV:       state_next = ST_STEP_GO;
            ST_STEP_GO:  state_next = ST_STEP_WAIT;
            ST_STEP_WAIT: begin
                if (unit_st.done) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:      state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs and unit operands
    always_comb begin
        s_ready         = (state_reg == ST_IDLE);
        unit_ctrl.start = 1'b0;
        unit_ctrl.op    = UOP_MULSL;
        unit_a          = '0;
        unit_b          = slice_b;
        case (state_reg)
            ST_ACC_GO: begin
                unit_ctrl.start = 1'b1;
                unit_a          = {32'b0, accel_reg};
            end
            ST_SQ_GO: begin
                unit_ctrl.start = 1'b1;
                unit_ctrl.op    = UOP_MUL;
                unit_a          = {31'b0, s_abs_w};
                unit_b          = {17'b0, s_abs_w};
            end
            ST_BRK_GO: begin
                unit_ctrl.start = 1'b1;
                unit_ctrl.op    = UOP_DIV;
                unit_a          = sq_reg;
                unit_b          = {17'b0, accel_reg, 1'b0};
            end
            ST_STEPM_GO: begin
                unit_ctrl.start = 1'b1;
                unit_a          = {31'b0, s_abs_w};
            end
            ST_QDIV_GO: begin
                unit_ctrl.start = 1'b1;
                unit_ctrl.op    = UOP_DIV;
                unit_a          = sq_reg;
                unit_b          = {absd_reg, 1'b0};
            end
            ST_QMUL_GO: begin
                unit_ctrl.start = 1'b1;
                unit_a          = dvmax_reg;
            end
            ST_STEP_GO: begin
                unit_ctrl.start = 1'b1;
                unit_a          = {28'b0, s_mag_w};
            end
            default: begin
                unit_ctrl.start = 1'b0;
            end
        endcase
    end

    assign cfg_ready  = 1'b1;
    assign m_valid    = m_valid_reg;
    assign m_position = m_position_reg;
    assign m_speed    = m_speed_reg;
    assign m_busy_res = m_busy_reg;
    assign m_finished = m_fin_reg;

    // motion state, configuration and control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            speed_reg   <= '0;
            mode_reg    <= MODE_POSITION;
            abs_reg     <= 1'b0;
            goal_reg    <= '0;
            cruise_reg  <= '0;
            accel_reg   <= '0;
            busy_reg    <= 1'b0;
            slice_reg   <= SLICE_RESET;
            fin_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_index == CFG_SLICE) begin
                slice_reg <= cfg_data;
            end
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    fin_reg <= 1'b0;
                    if (s_valid && s_kind == KIND_CMD) begin
                        mode_reg   <= s_ctrl_mode;
                        abs_reg    <= s_absolute_target;
                        goal_reg   <= s_target_position;
                        cruise_reg <= s_cruise_speed;
                        accel_reg  <= s_max_accel;
                        busy_reg   <= 1'b1;
                    end
                end
                ST_PLAN: begin
                    if (plan_arrive) begin
                        pos_reg   <= sat_pos(snap_sum);
                        speed_reg <= '0;
                        abs_reg   <= 1'b0;
                        goal_reg  <= '0;
                        busy_reg  <= 1'b0;
                        fin_reg   <= 1'b1;
                        if (mode_reg == MODE_TRAP) begin
                            mode_reg <= MODE_HOLD;
                        end
                    end
                end
                ST_UPD: begin
                    pos_reg   <= sat_pos(pos_sum);
                    speed_reg <= spd_new;
                    if (brake_mode) begin
                        if (spd_new == '0) begin
                            abs_reg  <= 1'b0;
                            goal_reg <= '0;
                            busy_reg <= 1'b0;
                            fin_reg  <= 1'b1;
                            mode_reg <= MODE_POSITION;
                        end
                    end else if (!abs_reg) begin
                        goal_reg <= sat_pos(goal_dif);
                    end
                end
                default: begin
                    fin_reg <= fin_reg;
                end
            endcase
        end
    end

    // working values and result word
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_ACC_WAIT: begin
                if (unit_st.done) begin
                    accsl_reg <= unit_res[30:0];
                    dvmax_reg <= {32'b0, unit_res[30:0]};
                    tgt_reg   <= '0;
                end
            end
            ST_SQ_WAIT: begin
                if (unit_st.done) begin
                    sq_reg  <= unit_res;
                    brk_reg <= (s_abs_w != '0) ? POS_MAX : '0;
                end
            end
            ST_BRK_WAIT: begin
                if (unit_st.done) begin
                    brk_reg <= (unit_res > {15'b0, POS_MAX}) ? POS_MAX : unit_res[POS_W-1:0];
                end
            end
            ST_STEPM_WAIT: begin
                if (unit_st.done) begin
                    stepm_reg <= unit_res[31:0];
                end
            end
            ST_PLAN: begin
                absd_reg  <= absd_w;
                tgt_reg   <= plan_tgt;
                dvmax_reg <= (plan_tgt == '0) ? DV_BIG : {32'b0, accsl_reg};
            end
            ST_QDIV_WAIT, ST_QMUL_WAIT: begin
                if (unit_st.done) begin
                    dvmax_reg <= unit_res;
                end
            end
            ST_DV: begin
                sdv_reg <= sdv_w;
            end
            ST_STEP_WAIT: begin
                if (unit_st.done) begin
                    st_reg <= st_w;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_position_reg <= pos_reg;
                    m_speed_reg    <= speed_reg;
                    m_busy_reg     <= busy_reg;
                    m_fin_reg      <= fin_reg;
                end
            end
            default: begin
                st_reg <= st_reg;
            end
        endcase
    end

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != ST_IDLE))
        else $error("accepted word did not start processing");

    a_idle_at_rest: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (speed_reg == '0 && goal_reg == '0 && !abs_reg))
        else $error("idle with motion state not at rest");

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        unit_st.done |-> (state_reg == ST_ACC_WAIT || state_reg == ST_SQ_WAIT
                       || state_reg == ST_BRK_WAIT || state_reg == ST_STEPM_WAIT
                       || state_reg == ST_QDIV_WAIT || state_reg == ST_QMUL_WAIT
                       || state_reg == ST_STEP_WAIT))
        else $error("unit finished outside a wait state");

    a_unit_free_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !unit_st.busy)
        else $error("shared unit busy while idle");

endmodule
